// ----- rtl/core/dshot_four_channel_frame_encoder_unit_assert.svh -----
// assertion macros for the dshot frame encoder
`ifndef DSHOT_FOUR_CHANNEL_FRAME_ENCODER_UNIT_ASSERT_SVH
`define DSHOT_FOUR_CHANNEL_FRAME_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("dfe check failed");

// next-cycle implication, checked out of reset
`define DFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("dfe check failed");

`endif

// ----- rtl/core/dfe_pkg.sv -----
// shared types and constants for the dshot frame encoder
package dfe_pkg;

	localparam int PACKET_BITS   = 16;
	localparam int CHANNEL_COUNT = 4;
	localparam int FRAME_SLOTS_DEFAULT = 20;

	localparam int THR_W   = 11;
	localparam int IN_W    = 16;
	localparam int TICK_W  = 16;
	localparam int SLOT_W  = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_THROTTLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_BIT_TICKS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIT_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TELEMETRY      = 3'd4;

	localparam logic [THR_W-1:0]  MIN_THROTTLE_RST   = 11'd48;
	localparam logic [THR_W-1:0]  MAX_THROTTLE_RST   = 11'd2047;
	localparam logic [TICK_W-1:0] ONE_BIT_TICKS_RST  = 16'd420;
	localparam logic [TICK_W-1:0] ZERO_BIT_TICKS_RST = 16'd210;

	typedef struct packed {
		logic [THR_W-1:0]  min_throttle;
		logic [THR_W-1:0]  max_throttle;
		logic [TICK_W-1:0] one_bit_ticks;
		logic [TICK_W-1:0] zero_bit_ticks;
		logic              telemetry_request;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic              gap;
		logic              last;
	} slot_ctl_t;

endpackage

// ----- rtl/core/dfe_lane.sv -----
// one channel lane: throttle normalization, packet build, bit shifter
module dfe_lane
	import dfe_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic            shift,
	input  logic [IN_W-1:0] throttle,
	input  cfg_t            cfg,
	output logic            bit_out
);

	logic [IN_W-1:0]        min_ext;
	logic [IN_W-1:0]        max_ext;
	logic [THR_W-1:0]       clipped;
	logic [THR_W-1:0]       norm;
	logic [THR_W:0]         p;
	logic [3:0]             crc;
	logic [PACKET_BITS-1:0] pkt_q;

	always_comb begin
		min_ext = IN_W'(cfg.min_throttle);
		max_ext = IN_W'(cfg.max_throttle);
		clipped = (throttle > max_ext) ? cfg.max_throttle : throttle[THR_W-1:0];
		// zero, reserved, or clamped below the minimum when limits cross
		if (throttle == '0 || throttle < min_ext || clipped < cfg.min_throttle) begin
			norm = '0;
		end else begin
			norm = clipped;
		end
		p   = {norm, cfg.telemetry_request};
		crc = p[3:0] ^ p[7:4] ^ p[11:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else if (load) begin
			pkt_q <= {p, crc};
		end else if (shift) begin
			pkt_q <= {pkt_q[PACKET_BITS-2:0], 1'b0};
		end
	end

	assign bit_out = pkt_q[PACKET_BITS-1];

endmodule

// ----- rtl/core/dfe_merge.sv -----
// merge stage: lane bits to compare ticks, registered slot result
module dfe_merge
	import dfe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  slot_ctl_t                ctl,
	input  logic [CHANNEL_COUNT-1:0] lane_bits,
	input  logic [TICK_W-1:0]        one_bit_ticks,
	input  logic [TICK_W-1:0]        zero_bit_ticks,
	output logic [TICK_W-1:0]        ticks [CHANNEL_COUNT],
	output logic [SLOT_W-1:0]        slot_number,
	output logic                     final_slot,
	output logic                     strobe
);

	logic [TICK_W-1:0] ticks_q [CHANNEL_COUNT];
	logic [SLOT_W-1:0] slot_q;
	logic              final_q;
	logic              strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CHANNEL_COUNT; i++) begin
			if (ctl.gap) begin
				ticks_q[i] <= '0;
			end else begin
				ticks_q[i] <= lane_bits[i] ? one_bit_ticks : zero_bit_ticks;
			end
		end
		slot_q  <= ctl.slot;
		final_q <= ctl.last;
	end

	assign ticks       = ticks_q;
	assign slot_number = slot_q;
	assign final_slot  = final_q;
	assign strobe      = strobe_q;

endmodule

// ----- rtl/core/dshot_four_channel_frame_encoder_unit.sv -----
// top level of the four channel dshot frame encoder
// start/busy command: a frame of four motor throttles is taken at a rising
// edge with start high and busy low. the block answers with one slot result
// per cycle, marked by strobe: slots 0..15 carry the packet bits msb first
// as compare ticks per channel, the remaining slots up to FRAME_SLOTS-1 are
// gap slots with zero ticks, and final_slot marks the last one.
// channel 1 takes motor 3, channel 2 motor 1, channel 3 motor 2, channel 4
// motor 4. slot 0 reaches the ports through the merge register, which takes
// it after the accepting edge has loaded the lanes and the slot counter.
// frames: the slot counter steps through every slot of a frame;
// busy drops while the counter is on the last slot so frames run back to back.
// results cannot be held off: strobe is high for exactly one cycle per slot.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready, to be written only while no frame is in flight; unknown indexes are
// ignored. reset clears the sequencer and loads the default register values.
`include "dshot_four_channel_frame_encoder_unit_assert.svh"

module dshot_four_channel_frame_encoder_unit
	import dfe_pkg::*;
#(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [IN_W-1:0]      motor1_throttle,
	input  logic [IN_W-1:0]      motor2_throttle,
	input  logic [IN_W-1:0]      motor3_throttle,
	input  logic [IN_W-1:0]      motor4_throttle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output logic                 strobe,
	output logic [TICK_W-1:0]    channel1_ticks,
	output logic [TICK_W-1:0]    channel2_ticks,
	output logic [TICK_W-1:0]    channel3_ticks,
	output logic [TICK_W-1:0]    channel4_ticks,
	output logic [SLOT_W-1:0]    slot_number,
	output logic                 final_slot
);

	localparam int CNT_W = $clog2(FRAME_SLOTS);
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(FRAME_SLOTS - 1);

	cfg_t                     cfg_q;
	logic                     active_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     accept;
	logic                     shift;
	slot_ctl_t                ctl;
	logic [IN_W-1:0]          lane_thr [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] lane_bits;
	logic [TICK_W-1:0]        ticks [CHANNEL_COUNT];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_throttle      <= MIN_THROTTLE_RST;
			cfg_q.max_throttle      <= MAX_THROTTLE_RST;
			cfg_q.one_bit_ticks     <= ONE_BIT_TICKS_RST;
			cfg_q.zero_bit_ticks    <= ZERO_BIT_TICKS_RST;
			cfg_q.telemetry_request <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_THROTTLE:   cfg_q.min_throttle      <= cfg_data[THR_W-1:0];
				CFG_MAX_THROTTLE:   cfg_q.max_throttle      <= cfg_data[THR_W-1:0];
				CFG_ONE_BIT_TICKS:  cfg_q.one_bit_ticks     <= cfg_data;
				CFG_ZERO_BIT_TICKS: cfg_q.zero_bit_ticks    <= cfg_data;
				CFG_TELEMETRY:      cfg_q.telemetry_request <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// the merge stage takes the last slot at this edge, so the next frame may load then
	assign busy   = active_q && (cnt_q != LAST_SLOT);
	assign accept = start && !busy;
	assign shift  = active_q && !accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (cnt_q == LAST_SLOT) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		ctl.valid = active_q;
		ctl.slot  = SLOT_W'(cnt_q);
		ctl.gap   = SLOT_W'(cnt_q) >= SLOT_W'(PACKET_BITS);
		ctl.last  = (cnt_q == LAST_SLOT);
	end

	// fixed motor to channel routing
	assign lane_thr[0] = motor3_throttle;
	assign lane_thr[1] = motor1_throttle;
	assign lane_thr[2] = motor2_throttle;
	assign lane_thr[3] = motor4_throttle;

	for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_lane
		dfe_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept),
			.shift    (shift),
			.throttle (lane_thr[g]),
			.cfg      (cfg_q),
			.bit_out  (lane_bits[g])
		);
	end

	dfe_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.lane_bits      (lane_bits),
		.one_bit_ticks  (cfg_q.one_bit_ticks),
		.zero_bit_ticks (cfg_q.zero_bit_ticks),
		.ticks          (ticks),
		.slot_number    (slot_number),
		.final_slot     (final_slot),
		.strobe         (strobe)
	);

	assign channel1_ticks = ticks[0];
	assign channel2_ticks = ticks[1];
	assign channel3_ticks = ticks[2];
	assign channel4_ticks = ticks[3];

	`DFE_ASSERT_SAME(a_first_slot, start && !busy, ##2 (strobe && slot_number == '0))
	`DFE_ASSERT_SAME(a_final_pos, strobe && final_slot, slot_number == SLOT_W'(FRAME_SLOTS - 1))
	`DFE_ASSERT_NEXT(a_frame_contig, strobe && !final_slot, strobe)
	`DFE_ASSERT_SAME(a_gap_zero, strobe && slot_number >= SLOT_W'(PACKET_BITS),
		(channel1_ticks == '0 && channel2_ticks == '0 && channel3_ticks == '0 && channel4_ticks == '0))

endmodule

// ----- tb/dshot_four_channel_frame_encoder_unit_checker.sv -----
// checker for the dshot frame encoder: predicts every slot result and compares
`timescale 1ns / 100ps

module dshot_four_channel_frame_encoder_unit_checker
	import dfe_pkg::*;
#(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [IN_W-1:0]      motor1_throttle,
	input  logic [IN_W-1:0]      motor2_throttle,
	input  logic [IN_W-1:0]      motor3_throttle,
	input  logic [IN_W-1:0]      motor4_throttle,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 strobe,
	input  logic [TICK_W-1:0]    channel1_ticks,
	input  logic [TICK_W-1:0]    channel2_ticks,
	input  logic [TICK_W-1:0]    channel3_ticks,
	input  logic [TICK_W-1:0]    channel4_ticks,
	input  logic [SLOT_W-1:0]    slot_number,
	input  logic                 final_slot,
	output int                   mismatch_count,
	output int                   outstanding,
	output int                   slots_checked
);

	typedef struct packed {
		int                                    frame_id;
		logic [CHANNEL_COUNT-1:0][TICK_W-1:0]  ticks;
		logic [SLOT_W-1:0]                     slot;
		logic                                  last;
	} slot_result_t;

	slot_result_t      expected_slot_q [$];
	int                frames_seen;

	// local copy of the encoder registers
	logic [THR_W-1:0]  lim_min;
	logic [THR_W-1:0]  lim_max;
	logic [TICK_W-1:0] one_ticks;
	logic [TICK_W-1:0] zero_ticks;
	logic              telem;

	initial begin
		mismatch_count = 0;
		slots_checked = 0;
		frames_seen = 0;
	end

	task automatic report_mismatch(input string field, input int frame_id,
		input int unsigned got, input int unsigned want);
		// keep the log short when something is badly broken
		if (mismatch_count < 30)
			$display("mismatch frame %0d %s: got %0d expected %0d", frame_id, field, got, want);
		mismatch_count++;
	endtask

	function automatic logic [THR_W-1:0] normalize_throttle(input logic [IN_W-1:0] raw);
		logic [IN_W-1:0] t;
		t = raw;
		if (t == '0 || t < lim_min)
			return '0;
		if (t > lim_max)
			t = IN_W'(lim_max);
		// crossed limits: the saturated value is still reserved
		if (t < lim_min)
			return '0;
		return t[THR_W-1:0];
	endfunction

	function automatic logic [PACKET_BITS-1:0] dshot_packet(input logic [THR_W-1:0] thr);
		logic [THR_W:0] p;
		logic [3:0]     crc;
		p = {thr, telem};
		crc = p[3:0] ^ p[7:4] ^ p[11:8];
		return {p, crc};
	endfunction

	task automatic queue_frame();
		logic [CHANNEL_COUNT-1:0][PACKET_BITS-1:0] pkt;
		slot_result_t r;
		pkt[0] = dshot_packet(normalize_throttle(motor3_throttle));
		pkt[1] = dshot_packet(normalize_throttle(motor1_throttle));
		pkt[2] = dshot_packet(normalize_throttle(motor2_throttle));
		pkt[3] = dshot_packet(normalize_throttle(motor4_throttle));
		for (int s = 0; s < FRAME_SLOTS; s++) begin
			r.frame_id = frames_seen;
			for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
				if (s < PACKET_BITS)
					r.ticks[ch] = pkt[ch][PACKET_BITS-1-s] ? one_ticks : zero_ticks;
				else
					r.ticks[ch] = '0;
			end
			r.slot = s[SLOT_W-1:0];
			r.last = (s == FRAME_SLOTS - 1);
			expected_slot_q.push_back(r);
		end
		frames_seen++;
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
		case (idx)
			CFG_MIN_THROTTLE: lim_min = data[THR_W-1:0];
			CFG_MAX_THROTTLE: lim_max = data[THR_W-1:0];
			CFG_ONE_BIT_TICKS: one_ticks = data;
			CFG_ZERO_BIT_TICKS: zero_ticks = data;
			CFG_TELEMETRY: telem = data[0];
			default: begin
				// other indexes leave the registers alone
			end
		endcase
	endtask

	task automatic check_slot();
		slot_result_t want;
		logic [CHANNEL_COUNT-1:0][TICK_W-1:0] got;
		if (expected_slot_q.size() == 0) begin
			report_mismatch("slot result with no frame pending", -1, 32'(slot_number), 0);
			return;
		end
		want = expected_slot_q.pop_front();
		got = {channel4_ticks, channel3_ticks, channel2_ticks, channel1_ticks};
		for (int ch = 0; ch < CHANNEL_COUNT; ch++)
			if (got[ch] !== want.ticks[ch])
				report_mismatch($sformatf("slot %0d channel%0d_ticks", want.slot, ch + 1),
					want.frame_id, 32'(got[ch]), 32'(want.ticks[ch]));
		if (slot_number !== want.slot)
			report_mismatch("slot_number", want.frame_id, 32'(slot_number), 32'(want.slot));
		if (final_slot !== want.last)
			report_mismatch($sformatf("slot %0d final_slot", want.slot), want.frame_id,
				32'(final_slot), 32'(want.last));
		slots_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_min = MIN_THROTTLE_RST;
			lim_max = MAX_THROTTLE_RST;
			one_ticks = ONE_BIT_TICKS_RST;
			zero_ticks = ZERO_BIT_TICKS_RST;
			telem = 1'b0;
			expected_slot_q.delete();
			outstanding <= 0;
		end else begin
			if (strobe)
				check_slot();
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (start && !busy)
				queue_frame();
			outstanding <= expected_slot_q.size();
		end
	end

endmodule

// ----- tb/dshot_four_channel_frame_encoder_unit_tb.sv -----
// testbench top for the dshot frame encoder: stimulus, register settings, verdict
`timescale 1ns / 100ps

module dshot_four_channel_frame_encoder_unit_tb;
	import dfe_pkg::*;

	localparam int FRAME_SLOTS  = FRAME_SLOTS_DEFAULT;
	localparam int LIMIT_CYCLES = 300000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_FRAMES  = 41;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [IN_W-1:0]      motor1_throttle;
	logic [IN_W-1:0]      motor2_throttle;
	logic [IN_W-1:0]      motor3_throttle;
	logic [IN_W-1:0]      motor4_throttle;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;
	logic                 strobe;
	logic [TICK_W-1:0]    channel1_ticks;
	logic [TICK_W-1:0]    channel2_ticks;
	logic [TICK_W-1:0]    channel3_ticks;
	logic [TICK_W-1:0]    channel4_ticks;
	logic [SLOT_W-1:0]    slot_number;
	logic                 final_slot;

	int mismatch_count;
	int outstanding;
	int slots_checked;
	int cycle_count = 0;
	int frames_sent = 0;
	int reg_writes = 0;
	int settings_used = 0;
	bit burst;

	// stimulus-side view of the limits, used to aim throttles at the edges
	logic [THR_W-1:0] cur_min = MIN_THROTTLE_RST;
	logic [THR_W-1:0] cur_max = MAX_THROTTLE_RST;

	dshot_four_channel_frame_encoder_unit #(.FRAME_SLOTS(FRAME_SLOTS)) uut (.*);

	dshot_four_channel_frame_encoder_unit_checker #(.FRAME_SLOTS(FRAME_SLOTS)) frame_checker (
		.*
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d slots still pending", cycle_count, outstanding);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [IN_W-1:0] rand_throttle();
		int unsigned r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 25)
			return IN_W'($urandom);
		if (r < 55)
			return IN_W'($urandom_range(0, 2047));
		if (r < 80) begin
			v = ($urandom_range(0, 1) ? int'(cur_min) : int'(cur_max)) + $urandom_range(0, 4) - 2;
			return (v < 0) ? '0 : v[IN_W-1:0];
		end
		if (r < 90) begin
			case ($urandom_range(0, 4))
				0: return 16'd0;
				1: return 16'd1;
				2: return 16'd2047;
				3: return 16'd2048;
				default: return 16'hFFFF;
			endcase
		end
		if (cur_min <= cur_max)
			return IN_W'($urandom_range(cur_min, cur_max));
		return IN_W'($urandom_range(0, 2047));
	endfunction

	task automatic send_frame(input logic [IN_W-1:0] m1, input logic [IN_W-1:0] m2,
		input logic [IN_W-1:0] m3, input logic [IN_W-1:0] m4);
		int unsigned gap;
		motor1_throttle <= m1;
		motor2_throttle <= m2;
		motor3_throttle <= m3;
		motor4_throttle <= m4;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		frames_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop start and let every pending slot drain before touching registers
	task automatic settle();
		if (start)
			start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
		repeat ($urandom_range(0, 2)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IDX_W'($urandom);
		cfg_data <= TICK_W'($urandom);
		if (idx == CFG_MIN_THROTTLE)
			cur_min = data[THR_W-1:0];
		if (idx == CFG_MAX_THROTTLE)
			cur_max = data[THR_W-1:0];
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic random_settings();
		logic [TICK_W-1:0] d;
		int unsigned r;
		r = $urandom_range(0, 99);
		d = TICK_W'($urandom);
		if (r < 60)
			d[THR_W-1:0] = THR_W'($urandom_range(1, 100));
		else if (r < 90)
			d[THR_W-1:0] = THR_W'($urandom_range(1, 2047));
		else if (r < 95)
			d[THR_W-1:0] = '0;
		else
			d[THR_W-1:0] = '1;
		write_reg(CFG_MIN_THROTTLE, d);
		r = $urandom_range(0, 99);
		d = TICK_W'($urandom);
		if (r < 60)
			d[THR_W-1:0] = THR_W'($urandom_range(1500, 2047));
		else if (r < 85)
			d[THR_W-1:0] = THR_W'($urandom_range(0, 2047));
		else if (r < 95)
			d[THR_W-1:0] = '1;
		else
			d[THR_W-1:0] = THR_W'($urandom_range(0, 1));
		write_reg(CFG_MAX_THROTTLE, d);
		write_reg(CFG_ONE_BIT_TICKS, ($urandom_range(0, 9) < 7) ? 16'($urandom)
			: ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
		write_reg(CFG_ZERO_BIT_TICKS, ($urandom_range(0, 9) < 7) ? 16'($urandom)
			: ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
		write_reg(CFG_TELEMETRY, TICK_W'($urandom));
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(CFG_TELEMETRY) + 1, 2**CFG_IDX_W - 1)),
				TICK_W'($urandom));
		settings_used++;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		motor1_throttle <= '0;
		motor2_throttle <= '0;
		motor3_throttle <= '0;
		motor4_throttle <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default registers: reserved range, limits, saturation, channel routing
		settings_used++;
		send_frame(16'd0, 16'd0, 16'd0, 16'd0);
		send_frame(16'd1, 16'd47, 16'd48, 16'd49);
		send_frame(16'd2047, 16'd2048, 16'hFFFF, 16'd46);
		send_frame(16'hAAAA, 16'h5555, 16'h0123, 16'h07FF);
		send_frame(16'd1000, 16'd1001, 16'd1002, 16'd1003);
		burst = 1'b1;
		send_frame(16'd48, 16'd2047, 16'd0, 16'hFFFF);
		send_frame(16'h0555, 16'h02AA, 16'h0400, 16'h0200);
		burst = 1'b0;
		settle();

		// unused indexes must not disturb anything; telemetry on, extreme ticks
		for (int i = int'(CFG_TELEMETRY) + 1; i < 2**CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), TICK_W'($urandom));
		write_reg(CFG_TELEMETRY, 16'hFFFF);
		write_reg(CFG_ONE_BIT_TICKS, 16'hFFFF);
		write_reg(CFG_ZERO_BIT_TICKS, 16'h0000);
		write_reg(CFG_MIN_THROTTLE, 16'hF801);
		write_reg(CFG_MAX_THROTTLE, 16'hFFFF);
		settings_used++;
		send_frame(16'd0, 16'd1, 16'd2, 16'd2047);
		send_frame(16'hFFFF, 16'd1024, 16'h0555, 16'h02AA);
		settle();
		write_reg(CFG_ONE_BIT_TICKS, 16'h0000);
		write_reg(CFG_ZERO_BIT_TICKS, 16'hFFFF);
		settings_used++;
		send_frame(16'd5, 16'd700, 16'd2046, 16'd3);
		settle();

		// crossed limits: everything encodes as zero throttle
		write_reg(CFG_MIN_THROTTLE, 16'd1000);
		write_reg(CFG_MAX_THROTTLE, 16'd500);
		settings_used++;
		send_frame(16'd0, 16'd499, 16'd500, 16'd1000);
		send_frame(16'd1500, 16'hFFFF, 16'd750, 16'd1);
		settle();

		// zero minimum, then zero maximum, then equal limits
		write_reg(CFG_MIN_THROTTLE, 16'd0);
		write_reg(CFG_MAX_THROTTLE, 16'd2047);
		settings_used++;
		send_frame(16'd0, 16'd1, 16'd2047, 16'hFFFF);
		settle();
		write_reg(CFG_MAX_THROTTLE, 16'd0);
		settings_used++;
		send_frame(16'd0, 16'd1, 16'd100, 16'hFFFF);
		settle();
		write_reg(CFG_MIN_THROTTLE, 16'd700);
		write_reg(CFG_MAX_THROTTLE, 16'd700);
		write_reg(CFG_TELEMETRY, 16'd0);
		settings_used++;
		send_frame(16'd699, 16'd700, 16'd701, 16'hFFFF);
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_settings();
			burst = ($urandom_range(0, 3) == 0);
			repeat (PHASE_FRAMES)
				send_frame(rand_throttle(), rand_throttle(), rand_throttle(), rand_throttle());
			burst = 1'b0;
			settle();
		end

		// trailing cycles catch any stray slot after the last frame
		repeat (3 * FRAME_SLOTS) @(posedge clk);
		$display("%0d frames over %0d register settings, %0d register writes",
			frames_sent, settings_used, reg_writes);
		$display("%0d slot results compared, %0d mismatches", slots_checked, mismatch_count);
		if (mismatch_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dfe_pkg.sv
rtl/core/dfe_lane.sv
rtl/core/dfe_merge.sv
rtl/core/dshot_four_channel_frame_encoder_unit.sv
tb/dshot_four_channel_frame_encoder_unit_checker.sv
tb/dshot_four_channel_frame_encoder_unit_tb.sv
